>>> rtl/bmp_row_pixel_unpacker_defines.svh
// Assertion macros for the BMP row pixel unpacker.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef BMP_ROW_PIXEL_UNPACKER_DEFINES_SVH
`define BMP_ROW_PIXEL_UNPACKER_DEFINES_SVH

// Condition holds at every clock edge outside reset
`define BMPU_ASSERT_ALWAYS(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Antecedent implies consequent in the same cycle
`define BMPU_ASSERT_IMPLY(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle
`define BMPU_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/bmpu_pkg.sv
// Shared types, constants and lookup functions for the BMP row pixel unpacker.
// No dependencies; imported by the top level and the output queue.
package bmpu_pkg;

    // Sizing
    localparam int MAX_ROW_PIXELS  = 4096;
    localparam int PIX_W           = $clog2(MAX_ROW_PIXELS + 1);
    localparam int ROWB_W          = PIX_W + 2;
    localparam int PROD_W          = PIX_W + 6;
    localparam int PALETTE_ENTRIES = 256;
    localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);
    localparam int COLOR_W         = 24;
    localparam int CFG_DATA_W      = 13;
    localparam int CFG_IDX_W       = 1;
    localparam int OUT_FIFO_DEPTH  = 4;
    localparam int OFF_AW          = $clog2(OUT_FIFO_DEPTH);
    localparam int OFF_CW          = $clog2(OUT_FIFO_DEPTH + 1);

    // Item kinds
    localparam logic KIND_PALETTE = 1'b0;
    localparam logic KIND_DATA    = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 1'b1;

    // Depth codes (code seven behaves as 32 bpp)
    localparam logic [2:0] DEPTH_1BPP  = 3'd0;
    localparam logic [2:0] DEPTH_2BPP  = 3'd1;
    localparam logic [2:0] DEPTH_4BPP  = 3'd2;
    localparam logic [2:0] DEPTH_8BPP  = 3'd3;
    localparam logic [2:0] DEPTH_16BPP = 3'd4;
    localparam logic [2:0] DEPTH_24BPP = 3'd5;
    localparam logic [2:0] DEPTH_32BPP = 3'd6;

    localparam logic [2:0]  DEPTH_RESET  = DEPTH_24BPP;
    localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;

    // One decoded pixel as it sits in the output queue
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       row_end;
    } pixel_t;

    // 5-bit to 8-bit channel widening
    function automatic logic [7:0] ramp5(input logic [4:0] v);
        logic [7:0] r;
        unique case (v)
            5'd0:  r = 8'd0;
            5'd1:  r = 8'd8;
            5'd2:  r = 8'd16;
            5'd3:  r = 8'd25;
            5'd4:  r = 8'd33;
            5'd5:  r = 8'd41;
            5'd6:  r = 8'd49;
            5'd7:  r = 8'd58;
            5'd8:  r = 8'd66;
            5'd9:  r = 8'd74;
            5'd10: r = 8'd82;
            5'd11: r = 8'd90;
            5'd12: r = 8'd99;
            5'd13: r = 8'd107;
            5'd14: r = 8'd115;
            5'd15: r = 8'd123;
            5'd16: r = 8'd132;
            5'd17: r = 8'd140;
            5'd18: r = 8'd148;
            5'd19: r = 8'd156;
            5'd20: r = 8'd165;
            5'd21: r = 8'd173;
            5'd22: r = 8'd181;
            5'd23: r = 8'd189;
            5'd24: r = 8'd197;
            5'd25: r = 8'd206;
            5'd26: r = 8'd214;
            5'd27: r = 8'd222;
            5'd28: r = 8'd230;
            5'd29: r = 8'd239;
            5'd30: r = 8'd247;
            5'd31: r = 8'd255;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/bmpu_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Read-before-write on a same-address collision. No dependencies.
module bmpu_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/bmpu_out_fifo.sv
// Small output queue of decoded pixels that decouples the result channel.
// Depends on bmpu_pkg (pixel_t, OUT_FIFO_DEPTH).
module bmpu_out_fifo (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  bmpu_pkg::pixel_t        push_data,
    output logic                    out_valid,
    input  logic                    out_stall,
    output bmpu_pkg::pixel_t        out_data,
    output logic [bmpu_pkg::OFF_CW-1:0] count
);
    import bmpu_pkg::*;

    pixel_t            mem_reg [OUT_FIFO_DEPTH];
    logic [OFF_AW-1:0] wr_ptr_reg;
    logic [OFF_AW-1:0] rd_ptr_reg;
    logic [OFF_CW-1:0] count_reg;
    logic              pop;

    assign pop       = out_valid && !out_stall;
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign count     = count_reg;

    // Storage; no reset on payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> rtl/bmp_row_pixel_unpacker.sv
// Top level of the BMP row pixel unpacker: row byte intake, palette RAM, output queue.
// Depends on bmpu_pkg, bmpu_ram, bmpu_out_fifo and bmp_row_pixel_unpacker_defines.svh.
//
//  channel | signals                                              | direction
//  --------+------------------------------------------------------+----------
//  input   | in_valid, in_stall, kind, palette_index,             | in
//          | palette_color, data_byte                             |
//  output  | out_valid, out_stall, red, green, blue, alpha,       | out
//          | row_end                                              |
//  config  | cfg_write, cfg_index, cfg_data                       | in
//
// One pixel per cycle leaves the unpack register while the output queue has room: the
// palette RAM has one read port, so a byte at 1/2/4/8 bpp issues up to 8/4/2/1 pixels
// in turn; bytes giving zero or one pixel are likewise taken every cycle. Pixels pass the
// unpack and RAM read stages. Reset clears row state and registers, not the palette contents.
// Intake stalls only while the unpack register still has pixels to issue, and issue
// pauses when the four-entry output queue plus the RAM read in flight is full.
module bmp_row_pixel_unpacker (
    input  logic                               clk,
    input  logic                               rst_n,
    // input channel
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               kind,
    input  logic [7:0]                         palette_index,
    input  logic [23:0]                        palette_color,
    input  logic [7:0]                         data_byte,
    // output channel
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [7:0]                         red,
    output logic [7:0]                         green,
    output logic [7:0]                         blue,
    output logic [7:0]                         alpha,
    output logic                               row_end,
    // configuration
    input  logic                               cfg_write,
    input  logic [bmpu_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bmpu_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import bmpu_pkg::*;

    `include "bmp_row_pixel_unpacker_defines.svh"

    // Configuration registers
    logic [2:0]             depth_code_reg;
    logic [CFG_DATA_W-1:0]  row_width_reg;

    // Row state
    logic [ROWB_W-1:0]      byte_pos_reg,  byte_pos_next;
    logic [PIX_W-1:0]       pix_count_reg, pix_count_next;
    logic [COLOR_W-1:0]     pend_reg,      pend_next;
    logic [1:0]             kpos_reg,      kpos_next;

    // Unpack register
    logic                   work_valid_reg,  work_valid_next;
    logic [3:0]             work_count_reg,  work_count_next;
    logic [7:0]             work_shift_reg,  work_shift_next;
    logic                   work_direct_reg, work_direct_next;
    logic [COLOR_W-1:0]     work_color_reg,  work_color_next;
    logic                   work_ends_reg,   work_ends_next;

    // RAM read stage
    logic                   b_valid_reg;
    logic                   b_direct_reg;
    logic [COLOR_W-1:0]     b_color_reg;
    logic                   b_row_end_reg;

    // Combinational helpers
    logic [PIX_W-1:0]       w_eff;
    logic [PROD_W-1:0]      row_bits;
    logic [ROWB_W-1:0]      row_bytes;
    logic [ROWB_W-1:0]      byte_pos_inc;
    logic [3:0]             per_byte;
    logic                   multi;
    logic [1:0]             k_last;
    logic [PIX_W-1:0]       pix_left;
    logic [3:0]             n_pix;
    logic [COLOR_W-1:0]     pend_upd;
    logic [COLOR_W-1:0]     direct_color;
    logic                   in_take;
    logic                   data_take;
    logic                   issue;
    logic                   issue_last;
    logic [PAL_AW-1:0]      pal_rd_addr;
    logic [7:0]             shift_adv;
    logic [COLOR_W-1:0]     pal_rd_data;
    logic [COLOR_W-1:0]     b_color_out;
    pixel_t                 push_pix;
    pixel_t                 out_pix;
    logic [OFF_CW-1:0]      fifo_count;

    // Effective width: zero acts as one, clamped to the maximum row
    always_comb
    begin
        if (row_width_reg == '0)
        begin
            w_eff = PIX_W'(1);
        end
        else if (int'(row_width_reg) > MAX_ROW_PIXELS)
        begin
            w_eff = PIX_W'(MAX_ROW_PIXELS);
        end
        else
        begin
            w_eff = PIX_W'(row_width_reg);
        end
    end

    // Row bits, padded row bytes, pixels per byte, multi-byte pixel shape
    always_comb
    begin
        row_bits = '0;
        per_byte = 4'd1;
        multi    = 1'b1;
        k_last   = 2'd3;
        unique case (depth_code_reg)
            DEPTH_1BPP:
            begin
                row_bits = PROD_W'(w_eff);
                per_byte = 4'd8;
                multi    = 1'b0;
            end
            DEPTH_2BPP:
            begin
                row_bits = PROD_W'(w_eff) << 1;
                per_byte = 4'd4;
                multi    = 1'b0;
            end
            DEPTH_4BPP:
            begin
                row_bits = PROD_W'(w_eff) << 2;
                per_byte = 4'd2;
                multi    = 1'b0;
            end
            DEPTH_8BPP:
            begin
                row_bits = PROD_W'(w_eff) << 3;
                multi    = 1'b0;
            end
            DEPTH_16BPP:
            begin
                row_bits = PROD_W'(w_eff) << 4;
                k_last   = 2'd1;
            end
            DEPTH_24BPP:
            begin
                row_bits = (PROD_W'(w_eff) << 4) + (PROD_W'(w_eff) << 3);
                k_last   = 2'd2;
            end
            default:
            begin
                row_bits = PROD_W'(w_eff) << 5;
            end
        endcase
        row_bytes = ROWB_W'((row_bits + PROD_W'(31)) >> 5) << 2;
    end

    // Pending bytes of a multi-byte pixel and the direct color it forms
    always_comb
    begin
        pend_upd = pend_reg;
        unique case (kpos_reg)
            2'd0:    pend_upd = {16'd0, data_byte};
            2'd1:    pend_upd = {8'd0, data_byte, pend_reg[7:0]};
            2'd2:    pend_upd = {data_byte, pend_reg[15:0]};
            default: pend_upd = pend_reg;
        endcase
        if (depth_code_reg == DEPTH_16BPP)
        begin
            direct_color = {ramp5(pend_upd[14:10]),
                            ramp5({pend_upd[9:8], pend_upd[7:5]}),
                            ramp5(pend_upd[4:0])};
        end
        else
        begin
            direct_color = pend_upd;
        end
    end

    // Pixel count this byte yields
    always_comb
    begin
        pix_left = (pix_count_reg < w_eff) ? (w_eff - pix_count_reg) : '0;
        if (multi)
        begin
            n_pix = ((kpos_reg == k_last) && (pix_left != '0)) ? 4'd1 : 4'd0;
        end
        else if (PIX_W'(per_byte) < pix_left)
        begin
            n_pix = per_byte;
        end
        else
        begin
            n_pix = pix_left[3:0];
        end
    end

    // Palette index of the next pixel and the shift to the one after it
    always_comb
    begin
        unique case (depth_code_reg)
            DEPTH_1BPP:
            begin
                pal_rd_addr = {7'd0, work_shift_reg[7]};
                shift_adv   = work_shift_reg << 1;
            end
            DEPTH_2BPP:
            begin
                pal_rd_addr = {6'd0, work_shift_reg[7:6]};
                shift_adv   = work_shift_reg << 2;
            end
            DEPTH_4BPP:
            begin
                pal_rd_addr = {4'd0, work_shift_reg[7:4]};
                shift_adv   = work_shift_reg << 4;
            end
            default:
            begin
                pal_rd_addr = work_shift_reg;
                shift_adv   = '0;
            end
        endcase
    end

    // Issue and intake handshake
    assign issue      = work_valid_reg
                        && ((int'(fifo_count) + int'(b_valid_reg)) < OUT_FIFO_DEPTH);
    assign issue_last = issue && (work_count_reg == 4'd1);
    assign in_stall   = work_valid_reg && !issue_last;
    assign in_take    = in_valid && !in_stall;
    assign data_take  = in_take && (kind == KIND_DATA);
    assign byte_pos_inc = byte_pos_reg + 1'b1;

    // Row state and unpack register next values
    always_comb
    begin
        byte_pos_next    = byte_pos_reg;
        pix_count_next   = pix_count_reg;
        pend_next        = pend_reg;
        kpos_next        = kpos_reg;
        work_valid_next  = work_valid_reg;
        work_count_next  = work_count_reg;
        work_shift_next  = work_shift_reg;
        work_direct_next = work_direct_reg;
        work_color_next  = work_color_reg;
        work_ends_next   = work_ends_reg;

        // advance the pixel being issued
        if (issue)
        begin
            work_count_next = work_count_reg - 1'b1;
            work_shift_next = shift_adv;
            if (issue_last)
            begin
                work_valid_next = 1'b0;
            end
        end

        // take a row byte
        if (data_take)
        begin
            pix_count_next = pix_count_reg + PIX_W'(n_pix);
            if (multi)
            begin
                pend_next = pend_upd;
                kpos_next = (kpos_reg == k_last) ? 2'd0 : kpos_reg + 1'b1;
            end
            if (n_pix != 4'd0)
            begin
                work_valid_next  = 1'b1;
                work_count_next  = n_pix;
                work_shift_next  = data_byte;
                work_direct_next = multi;
                work_color_next  = direct_color;
                work_ends_next   = ((pix_count_reg + PIX_W'(n_pix)) == w_eff);
            end
            if (byte_pos_inc >= row_bytes)
            begin
                byte_pos_next  = '0;
                pix_count_next = '0;
                pend_next      = '0;
                kpos_next      = '0;
            end
            else
            begin
                byte_pos_next = byte_pos_inc;
            end
        end

        // a register write restarts the row
        if (cfg_write)
        begin
            byte_pos_next  = '0;
            pix_count_next = '0;
            pend_next      = '0;
            kpos_next      = '0;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_code_reg <= DEPTH_RESET;
            row_width_reg  <= CFG_DATA_W'(1);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_DEPTH: depth_code_reg <= cfg_data[2:0];
                REG_WIDTH: row_width_reg  <= cfg_data;
            endcase
        end
    end

    // Row state and unpack control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_pos_reg   <= '0;
            pix_count_reg  <= '0;
            pend_reg       <= '0;
            kpos_reg       <= '0;
            work_valid_reg <= 1'b0;
            work_count_reg <= '0;
            b_valid_reg    <= 1'b0;
        end
        else
        begin
            byte_pos_reg   <= byte_pos_next;
            pix_count_reg  <= pix_count_next;
            pend_reg       <= pend_next;
            kpos_reg       <= kpos_next;
            work_valid_reg <= work_valid_next;
            work_count_reg <= work_count_next;
            b_valid_reg    <= issue;
        end
    end

    // Unpack and read-stage payload
    always_ff @(posedge clk)
    begin
        work_shift_reg  <= work_shift_next;
        work_direct_reg <= work_direct_next;
        work_color_reg  <= work_color_next;
        work_ends_reg   <= work_ends_next;
        if (issue)
        begin
            b_direct_reg  <= work_direct_reg;
            b_color_reg   <= work_color_reg;
            b_row_end_reg <= work_ends_reg && (work_count_reg == 4'd1);
        end
    end

    // Palette store; writes land in intake order behind earlier reads
    bmpu_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette (
        .clk     (clk),
        .wr_en   (in_take && (kind == KIND_PALETTE)),
        .wr_addr (palette_index),
        .wr_data (palette_color),
        .rd_en   (issue && !work_direct_reg),
        .rd_addr (pal_rd_addr),
        .rd_data (pal_rd_data)
    );

    // Pixel into the output queue
    assign b_color_out      = b_direct_reg ? b_color_reg : pal_rd_data;
    assign push_pix.red     = b_color_out[23:16];
    assign push_pix.green   = b_color_out[15:8];
    assign push_pix.blue    = b_color_out[7:0];
    assign push_pix.row_end = b_row_end_reg;

    bmpu_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (b_valid_reg),
        .push_data (push_pix),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_pix),
        .count     (fifo_count)
    );

    assign red     = out_pix.red;
    assign green   = out_pix.green;
    assign blue    = out_pix.blue;
    assign alpha   = ALPHA_OPAQUE;
    assign row_end = out_pix.row_end;

    // Checks
    `BMPU_ASSERT_ALWAYS(a_queue_room, (int'(fifo_count) + int'(b_valid_reg)) <= OUT_FIFO_DEPTH, "output queue overrun")
    `BMPU_ASSERT_IMPLY(a_work_count, work_valid_reg, (work_count_reg != 4'd0) && (work_count_reg <= 4'd8), "unpack count out of range")
    `BMPU_ASSERT_IMPLY(a_direct_single, work_valid_reg && work_direct_reg, work_count_reg == 4'd1, "direct pixel with count above one")
    `BMPU_ASSERT_NEXT(a_palette_no_work, in_take && (kind == KIND_PALETTE), !work_valid_reg, "palette write left pixels to issue")

endmodule

>>> sim/bmp_row_pixel_unpacker_tb.sv
// Self-checking testbench for the BMP row pixel unpacker: scripted and random row traffic.
// Depends on bmpu_pkg and the bmp_row_pixel_unpacker top level; reads no files.
`timescale 1ns / 100ps

module bmp_row_pixel_unpacker_tb;
    import bmpu_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 8;
    localparam int RANDOM_ITEMS = 106;
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_CYCLES  = 64;
    localparam int LIMIT_CYCLES = 200000;
    localparam int MAX_REPORTS  = 10;
    localparam int IDLE_PCT     = 30;

    // Code seven is not in the package; the block treats it as 32 bpp
    localparam logic [2:0] DEPTH_CODE7 = 3'd7;

    // 5-bit to 8-bit channel ramp for 16 bpp pixels
    localparam logic [7:0] WIDEN5 [32] = '{
        8'd0,   8'd8,   8'd16,  8'd25,  8'd33,  8'd41,  8'd49,  8'd58,
        8'd66,  8'd74,  8'd82,  8'd90,  8'd99,  8'd107, 8'd115, 8'd123,
        8'd132, 8'd140, 8'd148, 8'd156, 8'd165, 8'd173, 8'd181, 8'd189,
        8'd197, 8'd206, 8'd214, 8'd222, 8'd230, 8'd239, 8'd247, 8'd255
    };

    typedef enum logic [1:0] {ST_CFG, ST_PAL, ST_BYTE} script_op_t;

    // sel: register index or palette entry; val: register data, color or row byte
    typedef struct packed {
        script_op_t  op;
        logic [7:0]  sel;
        logic [23:0] val;
        logic        typed;
        pixel_t      px;
    } script_row_t;

    localparam int SCRIPT_LEN = 38;

    localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
        // reset state: 24 bpp, one pixel per row, four bytes per row
        '{ST_BYTE, 8'h00, 24'h00, 1'b0, '0},
        '{ST_BYTE, 8'h00, 24'h00, 1'b0, '0},
        '{ST_BYTE, 8'h00, 24'h00, 1'b1, '{8'h00, 8'h00, 8'h00, 1'b1}},
        '{ST_BYTE, 8'h00, 24'hA5, 1'b0, '0},
        '{ST_BYTE, 8'h00, 24'hFF, 1'b0, '0},
        '{ST_BYTE, 8'h00, 24'hFF, 1'b0, '0},
        '{ST_BYTE, 8'h00, 24'hFF, 1'b1, '{8'hFF, 8'hFF, 8'hFF, 1'b1}},
        // 16 bpp extremes, top bit of the high byte unused
        '{ST_CFG, 8'(REG_DEPTH), 24'(DEPTH_16BPP), 1'b0, '0},
        '{ST_CFG, 8'(REG_WIDTH), 24'd2, 1'b0, '0},
        '{ST_BYTE, 8'h00, 24'hFF, 1'b0, '0},
        '{ST_BYTE, 8'h00, 24'h7F, 1'b1, '{8'hFF, 8'hFF, 8'hFF, 1'b0}},
        '{ST_BYTE, 8'h00, 24'h00, 1'b0, '0},
        '{ST_BYTE, 8'h00, 24'h80, 1'b1, '{8'h00, 8'h00, 8'h00, 1'b1}},
        // palette load
        '{ST_PAL, 8'd0,   24'h000000, 1'b0, '0},
        '{ST_PAL, 8'd1,   24'hFFFFFF, 1'b0, '0},
        '{ST_PAL, 8'd2,   24'h00FF00, 1'b0, '0},
        '{ST_PAL, 8'd3,   24'hFF0000, 1'b0, '0},
        '{ST_PAL, 8'd15,  24'h0000FF, 1'b0, '0},
        '{ST_PAL, 8'd255, 24'h123456, 1'b0, '0},
        // 1 bpp, width zero acts as one; row left unfinished
        '{ST_CFG, 8'(REG_DEPTH), 24'(DEPTH_1BPP), 1'b0, '0},
        '{ST_CFG, 8'(REG_WIDTH), 24'd0, 1'b0, '0},
        '{ST_BYTE, 8'h00, 24'h80, 1'b1, '{8'hFF, 8'hFF, 8'hFF, 1'b1}},
        // 8 bpp, width all ones clamps to the maximum
        '{ST_CFG, 8'(REG_DEPTH), 24'(DEPTH_8BPP), 1'b0, '0},
        '{ST_CFG, 8'(REG_WIDTH), 24'h1FFF, 1'b0, '0},
        '{ST_BYTE, 8'h00, 24'hFF, 1'b1, '{8'h12, 8'h34, 8'h56, 1'b0}},
        '{ST_BYTE, 8'h00, 24'h00, 1'b1, '{8'h00, 8'h00, 8'h00, 1'b0}},
        // 2 bpp and 4 bpp; at 2 bpp the pixel past the width is dropped
        '{ST_CFG, 8'(REG_DEPTH), 24'(DEPTH_2BPP), 1'b0, '0},
        '{ST_CFG, 8'(REG_WIDTH), 24'd3, 1'b0, '0},
        '{ST_BYTE, 8'h00, 24'hE4, 1'b0, '0},
        '{ST_CFG, 8'(REG_DEPTH), 24'(DEPTH_4BPP), 1'b0, '0},
        '{ST_CFG, 8'(REG_WIDTH), 24'd2, 1'b0, '0},
        '{ST_BYTE, 8'h00, 24'hF0, 1'b0, '0},
        // code seven: 32 bpp, fourth byte ignored
        '{ST_CFG, 8'(REG_DEPTH), 24'(DEPTH_CODE7), 1'b0, '0},
        '{ST_CFG, 8'(REG_WIDTH), 24'd2, 1'b0, '0},
        '{ST_BYTE, 8'h00, 24'h01, 1'b0, '0},
        '{ST_BYTE, 8'h00, 24'h02, 1'b0, '0},
        '{ST_BYTE, 8'h00, 24'h03, 1'b0, '0},
        '{ST_BYTE, 8'h00, 24'h04, 1'b1, '{8'h03, 8'h02, 8'h01, 1'b0}}
    };

    // DUT ports
    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  in_valid      = 1'b0;
    logic                  in_stall;
    logic                  kind          = KIND_DATA;
    logic [7:0]            palette_index = '0;
    logic [23:0]           palette_color = '0;
    logic [7:0]            data_byte     = '0;
    logic                  out_valid;
    logic                  out_stall     = 1'b0;
    logic [7:0]            red;
    logic [7:0]            green;
    logic [7:0]            blue;
    logic [7:0]            alpha;
    logic                  row_end;
    logic                  cfg_write     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;

    // Decoder prediction state
    logic [23:0]           pal_mem [PALETTE_ENTRIES];
    bit                    pal_known [PALETTE_ENTRIES];
    logic [7:0]            known_idx [$];
    logic [2:0]            cur_depth  = DEPTH_RESET;
    logic [CFG_DATA_W-1:0] cur_width  = 13'd1;
    int unsigned           row_pos    = 0;
    int unsigned           row_pix    = 0;
    logic [23:0]           held_bytes = '0;
    pixel_t                step_px [$];
    pixel_t                pixels_due [$];
    bit                    typed_on   = 1'b0;
    pixel_t                typed_px   = '0;

    // Bookkeeping
    int          items_sent     = 0;
    int          pixels_checked = 0;
    int          errors         = 0;
    int          reports        = 0;
    int unsigned cycles         = 0;
    int          hold_left      = 0;
    bit          hold_done      = 1'b0;

    bmp_row_pixel_unpacker dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .kind          (kind),
        .palette_index (palette_index),
        .palette_color (palette_color),
        .data_byte     (data_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .alpha         (alpha),
        .row_end       (row_end),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // ---------------- prediction ----------------

    function automatic int unsigned depth_bits(input logic [2:0] code);
        case (code)
            DEPTH_1BPP:  return 1;
            DEPTH_2BPP:  return 2;
            DEPTH_4BPP:  return 4;
            DEPTH_8BPP:  return 8;
            DEPTH_16BPP: return 16;
            DEPTH_24BPP: return 24;
            default:     return 32;
        endcase
    endfunction

    function automatic int unsigned live_width();
        if (cur_width == 0)
            return 1;
        if (cur_width > MAX_ROW_PIXELS)
            return MAX_ROW_PIXELS;
        return 32'(cur_width);
    endfunction

    // Row length rounded up to whole 32-bit words
    function automatic int unsigned padded_row_bytes();
        return ((live_width() * depth_bits(cur_depth) + 31) / 32) * 4;
    endfunction

    function automatic bit calm();
        return items_sent >= 70 && items_sent < 100;
    endfunction

    task automatic restart_row();
        row_pos    = 0;
        row_pix    = 0;
        held_bytes = '0;
    endtask

    task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        if (idx == REG_DEPTH)
            cur_depth = val[2:0];
        else if (idx == REG_WIDTH)
            cur_width = val;
        restart_row();
    endtask

    // Pixels past the row width are swallowed
    task automatic push_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        pixel_t p;
        if (row_pix < live_width())
        begin
            row_pix++;
            p.red     = r;
            p.green   = g;
            p.blue    = b;
            p.row_end = (row_pix == live_width());
            step_px.push_back(p);
        end
    endtask

    task automatic decode_row_byte(input logic [7:0] d);
        int unsigned nbits;
        int unsigned nbytes;
        int unsigned k;
        int unsigned idx;
        logic [23:0] c;
        nbits = depth_bits(cur_depth);
        if (nbits <= 8)
        begin
            // indexed: MSB-first indices into the palette
            for (int i = 0; i < 8 / nbits; i++)
            begin
                idx = (int'(d) >> (8 - nbits * (i + 1))) & ((1 << nbits) - 1);
                c = pal_mem[idx];
                push_pixel(c[23:16], c[15:8], c[7:0]);
            end
        end
        else
        begin
            // direct color: little-endian bytes gathered per pixel
            nbytes = nbits / 8;
            k = row_pos % nbytes;
            if (k == 0)
                held_bytes = '0;
            if (k < 3)
                held_bytes[8*k +: 8] = d;
            if (k == nbytes - 1)
            begin
                if (nbytes == 2)
                    push_pixel(WIDEN5[held_bytes[14:10]], WIDEN5[held_bytes[9:5]],
                               WIDEN5[held_bytes[4:0]]);
                else
                    push_pixel(held_bytes[23:16], held_bytes[15:8], held_bytes[7:0]);
            end
        end
        row_pos++;
        if (row_pos >= padded_row_bytes())
            restart_row();
    endtask

    task automatic check_pixel();
        pixel_t want;
        if (pixels_due.size() == 0)
        begin
            errors++;
            if (reports < MAX_REPORTS)
            begin
                reports++;
                $display("[%0t] unexpected pixel r=%h g=%h b=%h a=%h end=%b",
                         $realtime, red, green, blue, alpha, row_end);
            end
        end
        else
        begin
            want = pixels_due.pop_front();
            pixels_checked++;
            if (red !== want.red || green !== want.green || blue !== want.blue ||
                alpha !== ALPHA_OPAQUE || row_end !== want.row_end)
            begin
                errors++;
                if (reports < MAX_REPORTS)
                begin
                    reports++;
                    $display("[%0t] pixel %0d mismatch: exp r=%h g=%h b=%h a=%h end=%b",
                             $realtime, pixels_checked, want.red, want.green, want.blue,
                             ALPHA_OPAQUE, want.row_end);
                    $display("          got r=%h g=%h b=%h a=%h end=%b",
                             red, green, blue, alpha, row_end);
                end
            end
        end
    endtask

    // Register writes, input transactions and output transactions seen at the clock edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_write)
                apply_reg(cfg_index, cfg_data);
            if (in_valid && !in_stall)
            begin
                items_sent++;
                step_px.delete();
                if (kind == KIND_PALETTE)
                begin
                    pal_mem[palette_index] = palette_color;
                    if (!pal_known[palette_index])
                    begin
                        pal_known[palette_index] = 1'b1;
                        known_idx.push_back(palette_index);
                    end
                end
                else
                    decode_row_byte(data_byte);
                if (typed_on)
                begin
                    pixels_due.push_back(typed_px);
                    typed_on = 1'b0;
                end
                else
                    foreach (step_px[i])
                        pixels_due.push_back(step_px[i]);
            end
            if (out_valid && !out_stall)
                check_pixel();
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receiver: random stalls, one long hold-off while the sender keeps offering
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (!hold_done && in_valid && items_sent >= 40)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else if (calm())
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
    end

    // ---------------- stimulus ----------------

    // Called at a falling edge; returns at the falling edge after acceptance with valid still high
    task automatic offer_item(input logic k, input logic [7:0] pi, input logic [23:0] pc,
                              input logic [7:0] db);
        while (!calm() && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid      <= 1'b1;
        kind          <= k;
        palette_index <= pi;
        palette_color <= pc;
        data_byte     <= db;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Quiesce: all pixels out, then let dropped bytes clear the pipe
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pixels_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        int unsigned rand_items;
        int unsigned phase;
        int unsigned nbytes;
        int unsigned pick;
        logic [2:0]  d;
        logic [CFG_DATA_W-1:0] dv;
        logic [CFG_DATA_W-1:0] wv;
        logic [7:0]  db;

        foreach (pal_mem[i])
            pal_mem[i] = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        wait_idle();

        // Scripted rows
        for (int s = 0; s < SCRIPT_LEN; s++)
        begin
            case (SCRIPT[s].op)
                ST_CFG:
                begin
                    wait_idle();
                    write_reg(SCRIPT[s].sel[CFG_IDX_W-1:0], SCRIPT[s].val[CFG_DATA_W-1:0]);
                end
                ST_PAL:
                begin
                    typed_on = 1'b0;
                    offer_item(KIND_PALETTE, SCRIPT[s].sel, SCRIPT[s].val, 8'h00);
                end
                default:
                begin
                    typed_on = SCRIPT[s].typed;
                    typed_px = SCRIPT[s].px;
                    offer_item(KIND_DATA, 8'h00, 24'h000000, SCRIPT[s].val[7:0]);
                end
            endcase
        end
        typed_on = 1'b0;

        // Fill the low sixteen entries so every sub-byte index is defined
        rand_items = 0;
        for (int e = 0; e < 16; e++)
        begin
            if (!pal_known[e])
            begin
                offer_item(KIND_PALETTE, 8'(e), 24'($urandom), 8'($urandom));
                rand_items++;
            end
        end

        // Random rows: mostly whole padded rows, some cut short by a register write
        phase = 0;
        while (rand_items < RANDOM_ITEMS)
        begin
            wait_idle();
            d = (phase == 0) ? DEPTH_32BPP : 3'($urandom_range(0, 7));
            dv = CFG_DATA_W'(d);
            if ($urandom_range(0, 3) == 0)
                dv[CFG_DATA_W-1:3] = (CFG_DATA_W - 3)'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 6)
                wv = CFG_DATA_W'(MAX_ROW_PIXELS);
            else if (pick < 9)
                wv = '0;
            else if (pick < 12)
                wv = CFG_DATA_W'($urandom_range(MAX_ROW_PIXELS + 1, 8191));
            else
                wv = CFG_DATA_W'($urandom_range(1, 12));
            pick = (phase == 0) ? 2 : $urandom_range(0, 3);
            if (pick != 1)
                write_reg(REG_DEPTH, dv);
            if (pick != 0)
                write_reg(REG_WIDTH, wv);
            phase++;

            nbytes = padded_row_bytes() * $urandom_range(1, 2);
            if (nbytes > 40)
                nbytes = $urandom_range(4, 40);
            if ($urandom_range(0, 4) == 0)
                nbytes = $urandom_range(1, nbytes);

            for (int j = 0; j < nbytes && rand_items < RANDOM_ITEMS; j++)
            begin
                if ($urandom_range(0, 99) < 12)
                begin
                    offer_item(KIND_PALETTE, 8'($urandom), 24'($urandom), 8'($urandom));
                    rand_items++;
                end
                // 8 bpp bytes are whole indices: only defined entries
                if (cur_depth == DEPTH_8BPP)
                    db = known_idx[$urandom_range(0, known_idx.size() - 1)];
                else
                    db = 8'($urandom);
                offer_item(KIND_DATA, 8'($urandom), 24'($urandom), db);
                rand_items++;
            end
        end

        wait_idle();
        errors += pixels_due.size();
        $display("Covered %0d transactions over %0d random register settings, all depth codes",
                 items_sent, phase);
        $display("%0d pixels compared, %0d errors, one %0d-cycle output hold-off",
                 pixels_checked, errors, HOLD_CYCLES);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
